// ===== rtl/stable_sorted_priority_queue_defines.svh =====
// ---------------------------------------------------------------------------
// stable sorted priority queue assertion macros
// short forms for the clocked, reset-gated properties used by the checker
// ---------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq check failed");

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the sorted priority queue modules
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ELEM_W       = 32;
	localparam int PRIO_W       = 16;
	localparam int COUNT_W      = 5;

	typedef enum logic {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} spq_func_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_FULL      = 2'd1,
		ERR_DEQ_EMPTY = 2'd2
	} spq_err_t;

	typedef struct packed {
		logic              func;
		logic [ELEM_W-1:0] elem_value;
		logic [PRIO_W-1:0] prio_value;
	} spq_cmd_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  head_elem;
		logic [PRIO_W-1:0]  head_prio;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic [1:0]         error_code;
	} spq_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [ELEM_W-1:0] elem;
	} spq_slot_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic      enq;
		logic      deq;
		spq_slot_t ins;
	} spq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/stable_sorted_priority_queue.sv =====
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue
// bounded min-first priority queue, stable for equal priorities, built as a
// chain of sorting cells
// ---------------------------------------------------------------------------
// channel    ports                 direction  transfer
// command    start, busy, cmd      in         start high while busy low
// result     done, rsp             out        done strobe, one cycle, no stall
//
// one transaction per cycle: every cell compares its priority with the new
// entry in parallel and shifts with its neighbor in the same cycle
// the result of a transaction shows in the cycle after it is taken
// busy stays low, the chain finishes each operation in the cycle it is taken
// reset empties the queue at once through the per-cell valid flags
// the result side cannot stall, so done is never held
// ---------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spq_pkg::spq_cmd_t cmd,
	output logic              done,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// chain wiring
	spq_slot_t slot [CAPACITY];
	logic      keep [CAPACITY];
	spq_ctl_t  ctl;

	// queue bookkeeping
	logic [CNT_W-1:0] count_q, count_d;
	spq_err_t         err_q, err_d;
	logic             done_q;
	logic             acc, full, empty;

	assign busy  = 1'b0;
	assign acc   = start && !busy;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// operation decode, full and empty cases leave the chain untouched
	always_comb begin
		ctl.enq = acc && (cmd.func == FUNC_ENQ) && !full;
		ctl.deq = acc && (cmd.func == FUNC_DEQ) && !empty;
		ctl.ins = '{valid: 1'b1, prio: cmd.prio_value, elem: cmd.elem_value};

		count_d = count_q;
		if (ctl.enq) begin
			count_d = count_q + 1'b1;
		end else if (ctl.deq) begin
			count_d = count_q - 1'b1;
		end

		err_d = ERR_OK;
		if (acc && (cmd.func == FUNC_ENQ) && full) begin
			err_d = ERR_FULL;
		end else if (acc && (cmd.func == FUNC_DEQ) && empty) begin
			err_d = ERR_DEQ_EMPTY;
		end
	end

	// row of cells, slot 0 is the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_slot_t left_slot, right_slot;
		logic      left_keep;

		if (i == 0) begin : g_head
			// head cell has nothing to its left, so it takes the new entry whenever it does not keep its own
			assign left_slot = '0;
			assign left_keep = 1'b1;
		end else begin : g_mid
			assign left_slot = slot[i-1];
			assign left_keep = keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			// tail empties on dequeue
			assign right_slot = '0;
		end else begin : g_body
			assign right_slot = slot[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left      (left_slot),
			.left_keep (left_keep),
			.right     (right_slot),
			.slot      (slot[i]),
			.keep      (keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ERR_OK;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			err_q   <= err_d;
			done_q  <= acc;
		end
	end

	// result reads the head cell after the update
	assign done            = done_q;
	assign rsp.head_elem   = slot[0].valid ? slot[0].elem : '0;
	assign rsp.head_prio   = slot[0].valid ? slot[0].prio : '0;
	assign rsp.entry_count = COUNT_W'(count_q);
	assign rsp.is_empty    = (count_q == '0);
	assign rsp.error_code  = err_q;

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ---------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds, takes the new entry or shifts
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::spq_ctl_t  ctl,
	input  spq_pkg::spq_slot_t left,
	input  logic               left_keep,
	input  spq_pkg::spq_slot_t right,
	output spq_pkg::spq_slot_t slot,
	output logic               keep
);
	import spq_pkg::*;

	logic              valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [ELEM_W-1:0] elem_q;
	spq_slot_t         slot_d;

	// entry stays put on insert when it sorts at or before the new one
	assign keep = valid_q && (prio_q <= ctl.ins.prio);
	assign slot = '{valid: valid_q, prio: prio_q, elem: elem_q};

	always_comb begin
		slot_d = slot;
		priority if (ctl.enq) begin
			if (!keep) begin
				if (left_keep) begin
					slot_d = ctl.ins;
				end else begin
					slot_d = left;
				end
			end
		end else if (ctl.deq) begin
			slot_d = right;
		end else begin
			slot_d = slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= slot_d.prio;
		elem_q <= slot_d.elem;
	end

endmodule

`default_nettype wire

// ===== rtl/spq_chk.sv =====
// ---------------------------------------------------------------------------
// spq_chk
// port-level checks for the sorted priority queue, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "stable_sorted_priority_queue_defines.svh"

module spq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input spq_pkg::spq_cmd_t cmd,
	input logic              done,
	input spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	`SPQ_ASSERT_NEXT(a_done_follows, start && !busy, done)
	`SPQ_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
	`SPQ_ASSERT_SAME(a_empty_flag, done, rsp.is_empty == (rsp.entry_count == '0))
	`SPQ_ASSERT_SAME(a_empty_head_zero, done && rsp.is_empty, (rsp.head_elem == '0) && (rsp.head_prio == '0))
	`SPQ_ASSERT_SAME(a_deq_empty_stays, done && (rsp.error_code == ERR_DEQ_EMPTY), rsp.is_empty)

endmodule

bind stable_sorted_priority_queue spq_chk u_spq_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the stable sorted priority queue: a scoreboard
// model of the sorted slots predicts every result, a driver feeds commands
// from a backlog with random gaps, and a monitor checks each done strobe
// ---------------------------------------------------------------------------

module tb;

	import spq_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int N_RANDOM    = 1925;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 4;
	localparam int MAX_PRINTS  = 30;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	spq_cmd_t cmd    = '0;
	logic     busy;
	logic     done;
	spq_rsp_t rsp;

	stable_sorted_priority_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	// commands waiting for the driver, results waiting for the monitor
	spq_cmd_t cmd_backlog[$];
	spq_rsp_t rsp_expected[$];

	// shadow copy of the sorted slots, slot 0 is the head
	logic [ELEM_W-1:0] sh_elem[CAP];
	logic [PRIO_W-1:0] sh_prio[CAP];
	int                sh_count = 0;

	int unsigned cycle_count  = 0;
	int unsigned n_mismatch   = 0;
	int unsigned n_sent       = 0;
	int unsigned n_enq        = 0;
	int unsigned n_deq        = 0;
	int unsigned n_full_rej   = 0;
	int unsigned n_empty_rej  = 0;
	int unsigned n_checked    = 0;
	int unsigned n_full_seen  = 0;

	// one line per mismatch, printing capped so a broken design stays readable
	task automatic report_mismatch(input string what);
		n_mismatch++;
		if (n_mismatch <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s", $time, what);
	endtask

	// apply one accepted transaction to the shadow queue and return the result
	function automatic spq_rsp_t pq_predict(input spq_cmd_t c);
		spq_rsp_t r;
		int       pos;
		int       k;
		r = '0;
		r.error_code = ERR_OK;
		if (c.func == FUNC_ENQ) begin
			n_enq++;
			if (sh_count >= CAP) begin
				r.error_code = ERR_FULL;
				n_full_rej++;
			end else begin
				// stable insert: new entry lands behind every entry of equal or lower priority
				pos = 0;
				while (pos < sh_count && sh_prio[pos] <= c.prio_value)
					pos++;
				for (k = sh_count; k > pos; k--) begin
					sh_elem[k] = sh_elem[k-1];
					sh_prio[k] = sh_prio[k-1];
				end
				sh_elem[pos] = c.elem_value;
				sh_prio[pos] = c.prio_value;
				sh_count++;
				if (sh_count == CAP)
					n_full_seen++;
			end
		end else begin
			n_deq++;
			if (sh_count == 0) begin
				r.error_code = ERR_DEQ_EMPTY;
				n_empty_rej++;
			end else begin
				for (k = 0; k + 1 < sh_count; k++) begin
					sh_elem[k] = sh_elem[k+1];
					sh_prio[k] = sh_prio[k+1];
				end
				sh_count--;
			end
		end
		// an empty queue reports a zero head
		if (sh_count > 0) begin
			r.head_elem = sh_elem[0];
			r.head_prio = sh_prio[0];
		end
		r.entry_count = COUNT_W'(sh_count);
		r.is_empty    = (sh_count == 0);
		return r;
	endfunction

	task automatic add_cmd(input spq_func_t f, input logic [ELEM_W-1:0] e,
			input logic [PRIO_W-1:0] p);
		spq_cmd_t c;
		c.func       = f;
		c.elem_value = e;
		c.prio_value = p;
		cmd_backlog.push_back(c);
	endtask

	// priority mix: tight range for many ties, full range, and the two extremes
	function automatic logic [PRIO_W-1:0] pick_prio();
		case ($urandom_range(3))
			0: return PRIO_W'($urandom_range(3));
			1: return $urandom_range(1) ? '1 : '0;
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	// driver: one command per transaction, random gaps except in a calm stretch
	always @(posedge clk) begin
		logic calm;
		logic gap;
		if (arst_n) begin
			calm = (n_sent >= 800 && n_sent < 1200);
			gap  = !calm && ($urandom_range(99) < 12);
			if (start && busy) begin
				// held off, keep the command steady
			end else begin
				if (start) begin
					// transaction taken at this edge
					rsp_expected.push_back(pq_predict(cmd));
					void'(cmd_backlog.pop_front());
					n_sent++;
				end
				if (cmd_backlog.size() != 0 && !gap) begin
					start <= 1'b1;
					cmd   <= cmd_backlog[0];
				end else begin
					start <= 1'b0;
					cmd   <= {1'($urandom), ELEM_W'($urandom), PRIO_W'($urandom)};
				end
			end
		end
	end

	// monitor: done can not be held, so every strobe is checked at once
	always @(posedge clk) begin
		spq_rsp_t want;
		if (arst_n && done) begin
			if (rsp_expected.size() == 0) begin
				report_mismatch("result strobe with no transaction outstanding");
			end else begin
				want = rsp_expected.pop_front();
				n_checked++;
				if (rsp.head_elem !== want.head_elem)
					report_mismatch($sformatf("head_elem got %h want %h",
						rsp.head_elem, want.head_elem));
				if (rsp.head_prio !== want.head_prio)
					report_mismatch($sformatf("head_prio got %h want %h",
						rsp.head_prio, want.head_prio));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count got %0d want %0d",
						rsp.entry_count, want.entry_count));
				if (rsp.is_empty !== want.is_empty)
					report_mismatch($sformatf("is_empty got %b want %b",
						rsp.is_empty, want.is_empty));
				if (rsp.error_code !== want.error_code)
					report_mismatch($sformatf("error_code got %0d want %0d",
						rsp.error_code, want.error_code));
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("stable_sorted_priority_queue: mismatch");
		$finish;
	end

	initial begin
		int       occ;
		logic     filling;
		spq_cmd_t c;

		// directed: dequeue on empty with a busy payload
		add_cmd(FUNC_DEQ, '1, '1);
		// payload and priority extremes
		add_cmd(FUNC_ENQ, '0, '1);
		add_cmd(FUNC_ENQ, '1, '0);
		// equal priorities must leave in arrival order
		add_cmd(FUNC_ENQ, 32'h0000_0001, 16'h1234);
		add_cmd(FUNC_ENQ, 32'h0000_0002, 16'h1234);
		add_cmd(FUNC_ENQ, 32'h0000_0003, 16'h1234);
		// tie with the head goes behind it
		add_cmd(FUNC_ENQ, 32'hA5A5_A5A5, 16'h0000);
		// fill to one below capacity with falling priorities so each insert lands ahead of the last
		for (int i = 0; i < CAP - 7; i++)
			add_cmd(FUNC_ENQ, $urandom, PRIO_W'(16'h8000 - i * 16'h0800));
		// this enqueue fills the queue to capacity
		add_cmd(FUNC_ENQ, 32'hDEAD_BEEF, '0);
		// dequeues ignore their payload
		for (int i = 0; i < 8; i++)
			add_cmd(FUNC_DEQ, $urandom, PRIO_W'($urandom));

		// random: alternate fill and drain phases so full and empty recur
		occ     = 8;
		filling = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (occ == CAP && $urandom_range(2) == 0)
				filling = 1'b0;
			else if (occ == 0 && $urandom_range(2) == 0)
				filling = 1'b1;
			else if ($urandom_range(39) == 0)
				filling = !filling;
			c.elem_value = $urandom;
			c.prio_value = pick_prio();
			if ($urandom_range(99) < (filling ? 75 : 25)) begin
				c.func = FUNC_ENQ;
				if (occ < CAP)
					occ++;
			end else begin
				c.func = FUNC_DEQ;
				if (occ > 0)
					occ--;
			end
			cmd_backlog.push_back(c);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d transactions: %0d enqueue, %0d dequeue, %0d results checked",
			n_sent, n_enq, n_deq, n_checked);
		$display("queue filled %0d times, %0d full rejects, %0d empty rejects, %0d mismatches",
			n_full_seen, n_full_rej, n_empty_rej, n_mismatch);
		if (n_mismatch == 0)
			$display("stable_sorted_priority_queue: match");
		else
			$display("stable_sorted_priority_queue: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_sorted_priority_queue.sv
rtl/spq_chk.sv
tb/tb.sv
